>>> design/adsr_pkg.sv
// shared types, codes and widths for the adsr envelope generator
// no dependencies; every other design file uses it by scoped names

package adsr_pkg;

  localparam int COUNT_BITS    = 24;
  localparam int FRAC_BITS     = 15;
  localparam int LEN_BITS      = 24;
  localparam int LVL_BITS      = 16;
  localparam int AMP_OUT_BITS  = 16;
  localparam int CMD_BITS      = 2;
  localparam int STAGE_BITS    = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam int AMP_BITS     = FRAC_BITS + 1;
  localparam int QUO_BITS     = AMP_BITS;
  localparam int PROD_BITS    = LEN_BITS + AMP_BITS;
  localparam int SUM_BITS     = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 2;
  localparam int SUS_CMP_BITS = (LVL_BITS > AMP_BITS) ? LVL_BITS : AMP_BITS;
  localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);

  localparam logic [AMP_BITS-1:0]   ONE_FX        = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [LVL_BITS-1:0]   SUSTAIN_RESET = 16'd32768;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODE    = 3'd0,
    CFG_ATTACK  = 3'd1,
    CFG_DECAY   = 3'd2,
    CFG_HOLD    = 3'd3,
    CFG_RELEASE = 3'd4,
    CFG_SUSTAIN = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    MODE_ADSR  = 1'b0,
    MODE_ADHSR = 1'b1
  } mode_t;

  typedef enum logic [STAGE_BITS-1:0] {
    STAGE_ATTACK  = 2'd0,
    STAGE_DECAY   = 2'd1,
    STAGE_SUSTAIN = 2'd2,
    STAGE_RELEASE = 2'd3
  } stage_t;

  typedef enum logic [2:0] {
    AMP_QUOT      = 3'd0,
    AMP_ONE_MINUS = 3'd1,
    AMP_SUS_MINUS = 3'd2,
    AMP_SUS       = 3'd3,
    AMP_ZERO      = 3'd4
  } amp_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_CLASSIFY  = 3'd1,
    ST_MULT      = 3'd2,
    ST_DIV_START = 3'd3,
    ST_DIV_WAIT  = 3'd4,
    ST_OUT       = 3'd5
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic classify;
    logic mult;
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic div_done;
  } dp_status_t;

endpackage

>>> design/adsr_if.sv
// valid/ready channel interfaces for command words and envelope result words
// depends on adsr_pkg

interface adsr_in_if;
  logic                           valid;
  logic                           ready;
  logic [adsr_pkg::CMD_BITS-1:0]  command;
  logic [adsr_pkg::LEN_BITS-1:0]  release_at;

  modport source (output valid, command, release_at, input ready);
  modport sink   (input valid, command, release_at, output ready);
endinterface

interface adsr_out_if;
  logic                              valid;
  logic                              ready;
  logic [adsr_pkg::AMP_OUT_BITS-1:0] amplitude;
  logic [adsr_pkg::STAGE_BITS-1:0]   stage;
  logic                              finished;

  modport source (output valid, amplitude, stage, finished, input ready);
  modport sink   (input valid, amplitude, stage, finished, output ready);
endinterface

>>> design/adsr_envelope_generator_core.sv
// top level of the linear adsr / adhsr envelope generator
// depends on adsr_pkg, adsr_if, adsr_ctrl and adsr_dp
//
// One command word is taken at a time. A press or release request is absorbed
// in its accept cycle and yields no result; the block is ready again at once.
// A tick yields one result word and occupies the block from accept to the next
// possible accept: phase select, the 24 by 16 multiply and divider load,
// then one quotient bit per cycle in the restoring divider (Q1.15), then
// the result register. A finished result waits in its register while the
// next command is accepted; a tick that completes before that result is
// taken stalls until the register frees up.
// Configuration writes land on the next edge and should be made while no tick
// is in progress. The sample counter saturates at its maximum.

module adsr_envelope_generator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  adsr_in_if.sink                             in_ch,
  adsr_out_if.source                          out_ch
);

  adsr_pkg::dp_cmd_t    dp_cmd;
  adsr_pkg::dp_status_t dp_status;
  logic                 out_valid;
  logic                 in_ready;

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  adsr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_command    (in_ch.command),
    .in_release_at (in_ch.release_at),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .out_amplitude (out_ch.amplitude),
    .out_stage     (out_ch.stage),
    .out_finished  (out_ch.finished)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result word overwritten before it was taken");

  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.accept && dp_status.is_tick) |=> dp_cmd.classify)
    else $error("accepted tick did not start phase select");

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.div_start |=> !dp_status.div_done)
    else $error("divider reported done right after start");

  a_idle_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.classify || dp_cmd.mult || dp_cmd.div_start) |-> !in_ch.ready)
    else $error("input accepted while a tick is in progress");
`endif

endmodule

>>> design/adsr_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_BITS
// depends on adsr_pkg

module adsr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [adsr_pkg::PROD_BITS-1:0]    num,
  input  logic [adsr_pkg::LEN_BITS-1:0]     den,
  output logic                              done,
  output logic [adsr_pkg::QUO_BITS-1:0]     quo
);

  logic [adsr_pkg::LEN_BITS-1:0]     rem_r;
  logic [adsr_pkg::QUO_BITS-1:0]     nlo_r;
  logic [adsr_pkg::QUO_BITS-1:0]     quo_r;
  logic [adsr_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                              busy_r;
  logic                              done_r;

  logic [adsr_pkg::LEN_BITS:0] trial;
  logic [adsr_pkg::LEN_BITS:0] diff;
  logic                        fits;

  assign trial = {rem_r, nlo_r[adsr_pkg::QUO_BITS-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == adsr_pkg::DIV_CNT_BITS'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= adsr_pkg::DIV_CNT_BITS'(adsr_pkg::QUO_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - adsr_pkg::DIV_CNT_BITS'(1);
        if (cnt_r == adsr_pkg::DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[adsr_pkg::PROD_BITS-1:adsr_pkg::QUO_BITS];
      nlo_r <= num[adsr_pkg::QUO_BITS-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[adsr_pkg::LEN_BITS-1:0] : trial[adsr_pkg::LEN_BITS-1:0];
      nlo_r <= {nlo_r[adsr_pkg::QUO_BITS-2:0], 1'b0};
      quo_r <= {quo_r[adsr_pkg::QUO_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> design/adsr_dp.sv
// envelope datapath: config registers, sample counter, phase select, multiply,
// divide and output register; depends on adsr_pkg and adsr_div

module adsr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic [adsr_pkg::CMD_BITS-1:0]       in_command,
  input  logic [adsr_pkg::LEN_BITS-1:0]       in_release_at,
  input  adsr_pkg::dp_cmd_t                   cmd,
  output adsr_pkg::dp_status_t                status,
  output logic [adsr_pkg::AMP_OUT_BITS-1:0]   out_amplitude,
  output logic [adsr_pkg::STAGE_BITS-1:0]     out_stage,
  output logic                                out_finished
);

  adsr_pkg::mode_t                 mode_r;
  logic [adsr_pkg::LEN_BITS-1:0]   attack_len_r;
  logic [adsr_pkg::LEN_BITS-1:0]   decay_len_r;
  logic [adsr_pkg::LEN_BITS-1:0]   hold_len_r;
  logic [adsr_pkg::LEN_BITS-1:0]   release_len_r;
  logic [adsr_pkg::LVL_BITS-1:0]   sustain_level_r;

  logic [adsr_pkg::COUNT_BITS-1:0] sample_count_r;
  logic [adsr_pkg::COUNT_BITS-1:0] release_pos_r;
  logic [adsr_pkg::COUNT_BITS-1:0] count_nxt;

  adsr_pkg::stage_t                stage_r;
  adsr_pkg::amp_kind_t             kind_r;
  logic [adsr_pkg::LEN_BITS-1:0]   x_r;
  logic [adsr_pkg::AMP_BITS-1:0]   y_r;
  logic [adsr_pkg::LEN_BITS-1:0]   den_r;
  logic                            fin_r;
  logic [adsr_pkg::AMP_BITS-1:0]   sus_r;
  logic [adsr_pkg::PROD_BITS-1:0]  prod_r;

  logic [adsr_pkg::AMP_OUT_BITS-1:0] out_amp_r;
  adsr_pkg::stage_t                  out_stage_r;
  logic                              out_fin_r;

  logic [adsr_pkg::SUM_BITS-1:0] s_ext, a_ext, d_ext, h_ext, r_ext, rp_ext, nx_ext;
  logic [adsr_pkg::SUM_BITS-1:0] ad, adh, adhr, start_pos, rel_d_full;
  logic [adsr_pkg::LEN_BITS-1:0] rel_d;
  logic [adsr_pkg::AMP_BITS-1:0] sus;
  logic                          fin;

  adsr_pkg::stage_t              stage_c;
  adsr_pkg::amp_kind_t           kind_c;
  logic [adsr_pkg::LEN_BITS-1:0] x_c;
  logic [adsr_pkg::AMP_BITS-1:0] y_c;
  logic [adsr_pkg::LEN_BITS-1:0] den_c;

  logic [adsr_pkg::QUO_BITS-1:0] quo;
  logic                          div_done;
  logic [adsr_pkg::AMP_BITS-1:0] amp;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= adsr_pkg::MODE_ADSR;
      attack_len_r    <= '0;
      decay_len_r     <= '0;
      hold_len_r      <= '0;
      release_len_r   <= '0;
      sustain_level_r <= adsr_pkg::SUSTAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adsr_pkg::CFG_MODE:    mode_r          <= adsr_pkg::mode_t'(cfg_wdata[0]);
        adsr_pkg::CFG_ATTACK:  attack_len_r    <= cfg_wdata[adsr_pkg::LEN_BITS-1:0];
        adsr_pkg::CFG_DECAY:   decay_len_r     <= cfg_wdata[adsr_pkg::LEN_BITS-1:0];
        adsr_pkg::CFG_HOLD:    hold_len_r      <= cfg_wdata[adsr_pkg::LEN_BITS-1:0];
        adsr_pkg::CFG_RELEASE: release_len_r   <= cfg_wdata[adsr_pkg::LEN_BITS-1:0];
        adsr_pkg::CFG_SUSTAIN: sustain_level_r <= cfg_wdata[adsr_pkg::LVL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // phase select
  always_comb begin
    s_ext  = adsr_pkg::SUM_BITS'(sample_count_r);
    a_ext  = adsr_pkg::SUM_BITS'(attack_len_r);
    d_ext  = adsr_pkg::SUM_BITS'(decay_len_r);
    h_ext  = adsr_pkg::SUM_BITS'(hold_len_r);
    r_ext  = adsr_pkg::SUM_BITS'(release_len_r);
    rp_ext = adsr_pkg::SUM_BITS'(release_pos_r);
    ad     = a_ext + d_ext;
    adh    = ad + h_ext;
    adhr   = adh + r_ext;

    if (adsr_pkg::SUS_CMP_BITS'(sustain_level_r) > adsr_pkg::SUS_CMP_BITS'(adsr_pkg::ONE_FX)) begin
      sus = adsr_pkg::ONE_FX;
    end else begin
      sus = adsr_pkg::AMP_BITS'(sustain_level_r);
    end

    start_pos  = (rp_ext > ad) ? rp_ext : ad;
    rel_d_full = s_ext - ((mode_r == adsr_pkg::MODE_ADSR) ? start_pos : adh);
    rel_d      = (rel_d_full > r_ext) ? release_len_r
                                      : rel_d_full[adsr_pkg::LEN_BITS-1:0];

    priority if (s_ext < a_ext) begin
      stage_c = adsr_pkg::STAGE_ATTACK;
      kind_c  = adsr_pkg::AMP_QUOT;
      x_c     = s_ext[adsr_pkg::LEN_BITS-1:0];
      y_c     = adsr_pkg::ONE_FX;
      den_c   = attack_len_r;
    end else if (s_ext < ad) begin
      stage_c = adsr_pkg::STAGE_DECAY;
      kind_c  = adsr_pkg::AMP_ONE_MINUS;
      x_c     = adsr_pkg::LEN_BITS'(s_ext - a_ext);
      y_c     = adsr_pkg::ONE_FX - sus;
      den_c   = decay_len_r;
    end else if ((mode_r == adsr_pkg::MODE_ADSR && (rp_ext == '0 || s_ext < rp_ext)) ||
                 (mode_r == adsr_pkg::MODE_ADHSR && s_ext < adh)) begin
      stage_c = adsr_pkg::STAGE_SUSTAIN;
      kind_c  = adsr_pkg::AMP_SUS;
      x_c     = '0;
      y_c     = '0;
      den_c   = adsr_pkg::LEN_BITS'(1);
    end else begin
      stage_c = adsr_pkg::STAGE_RELEASE;
      kind_c  = (release_len_r == '0) ? adsr_pkg::AMP_ZERO : adsr_pkg::AMP_SUS_MINUS;
      x_c     = rel_d;
      y_c     = sus;
      den_c   = release_len_r;
    end

    count_nxt = (sample_count_r == adsr_pkg::COUNT_MAX) ? sample_count_r
                : sample_count_r + adsr_pkg::COUNT_BITS'(1);
    nx_ext    = adsr_pkg::SUM_BITS'(count_nxt);
    if (mode_r == adsr_pkg::MODE_ADSR) begin
      fin = (rp_ext != '0) && (nx_ext >= rp_ext) && ((nx_ext - rp_ext) >= r_ext);
    end else begin
      fin = nx_ext > adhr;
    end
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      release_pos_r  <= '0;
    end else if (cmd.accept) begin
      unique case (in_command)
        adsr_pkg::CMD_PRESS: begin
          sample_count_r <= '0;
          release_pos_r  <= '0;
        end
        adsr_pkg::CMD_RELEASE: release_pos_r <= adsr_pkg::COUNT_BITS'(in_release_at);
        default: ;
      endcase
    end else if (cmd.classify) begin
      sample_count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      stage_r <= stage_c;
      kind_r  <= kind_c;
      x_r     <= x_c;
      y_r     <= y_c;
      den_r   <= den_c;
      fin_r   <= fin;
      sus_r   <= sus;
    end
    if (cmd.mult) begin
      prod_r <= adsr_pkg::PROD_BITS'(x_r) * adsr_pkg::PROD_BITS'(y_r);
    end
  end

  adsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    unique case (kind_r)
      adsr_pkg::AMP_QUOT:      amp = quo;
      adsr_pkg::AMP_ONE_MINUS: amp = adsr_pkg::ONE_FX - quo;
      adsr_pkg::AMP_SUS_MINUS: amp = sus_r - quo;
      adsr_pkg::AMP_SUS:       amp = sus_r;
      default:                 amp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_amp_r   <= adsr_pkg::AMP_OUT_BITS'(amp);
      out_stage_r <= stage_r;
      out_fin_r   <= fin_r;
    end
  end

  assign status.is_tick  = (in_command == adsr_pkg::CMD_TICK);
  assign status.div_done = div_done;
  assign out_amplitude   = out_amp_r;
  assign out_stage       = out_stage_r;
  assign out_finished    = out_fin_r;

endmodule

>>> design/adsr_ctrl.sv
// envelope controller: sequences phase select, multiply, divide and output load
// depends on adsr_pkg

module adsr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  adsr_pkg::dp_status_t  status,
  output adsr_pkg::dp_cmd_t     cmd
);

  adsr_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      adsr_pkg::ST_IDLE: begin
        if (in_valid && status.is_tick) begin
          state_nxt = adsr_pkg::ST_CLASSIFY;
        end
      end
      adsr_pkg::ST_CLASSIFY:  state_nxt = adsr_pkg::ST_MULT;
      adsr_pkg::ST_MULT:      state_nxt = adsr_pkg::ST_DIV_START;
      adsr_pkg::ST_DIV_START: state_nxt = adsr_pkg::ST_DIV_WAIT;
      adsr_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_nxt = adsr_pkg::ST_OUT;
        end
      end
      adsr_pkg::ST_OUT: begin
        if (slot_free) begin
          state_nxt = adsr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = adsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == adsr_pkg::ST_IDLE);
    cmd.accept    = in_valid && (state_r == adsr_pkg::ST_IDLE);
    cmd.classify  = (state_r == adsr_pkg::ST_CLASSIFY);
    cmd.mult      = (state_r == adsr_pkg::ST_MULT);
    cmd.div_start = (state_r == adsr_pkg::ST_DIV_START);
    cmd.out_load  = (state_r == adsr_pkg::ST_OUT) && slot_free;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adsr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
